### hw/rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants of the sprite command stream decoder
// Command codes, stream opcodes, field widths and the palette access bundle.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int CW       = 14;   // column, row and run counters
  localparam int BYTE_W   = 8;
  localparam int RGB_W    = 24;
  localparam int PAL_AW   = 8;
  localparam int PAL_DEPTH = 256;
  localparam int ADDR_W   = 17;
  localparam int LEN_W    = 16;
  localparam int WIDTH_W  = 10;
  localparam int HEIGHT_W = 9;
  localparam int CFG_IDX_W = 2;

  // request kinds on the input channel
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_PAL   = 2'd2;

  // opcodes in the low bits of a stream word
  localparam logic [1:0] OP_COL = 2'd0;
  localparam logic [1:0] OP_RUN = 2'd1;
  localparam logic [1:0] OP_ROW = 2'd2;
  localparam logic [1:0] OP_END = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] waddr;
    logic [RGB_W-1:0]  wdata;
    logic              re;
    logic [PAL_AW-1:0] raddr;
  } pal_req_t;

endpackage

### hw/rtl/sprite_command_stream_decoder.sv
// ----------------------------------------------------------------------------
// sprite_command_stream_decoder: sprite byte stream to pixel writes
// Pairs stream bytes into command words, runs palette lookups, emits pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : requests. in_tuser = kind (start image, stream byte, palette write),
//           in_tdata = stream byte, palette index, packed RGB.
//   out_* : results, at most one per request. out_tlast marks the end of the
//           decode, out_tuser flags a pixel write or a dropped off-frame pixel.
//   cfg_* : width, height and byte budget; always ready, write only when idle.
// Throughput: one request per cycle, sustained while out_tready is high. Every request costs one
//   palette memory port access at most (write or read), and the decode state
//   updates in the acceptance cycle.
// Output path: an accepted request's result is registered in the address
//   stage (palette read and address multiply share one stage), then in the
//   output queue, whose head drives out_tvalid.
// Stall: a two-entry output queue absorbs results while out_tready is low;
//   in_tready drops only when the queue plus the stage in flight would
//   overflow, and requests that give no result still need that slot free.
// Reset: decoder idle, counters zero, registers at 320 x 200 and budget 0.
//   The palette memory is not cleared; entries read before written are
//   undefined.
// ----------------------------------------------------------------------------
module sprite_command_stream_decoder #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: stream_byte[7:0], palette_index[15:8], palette_rgb[39:16]
  input  logic [39:0]                       in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: pixel_address[16:0], red[24:17], green[32:25], blue[40:33], zeros
  output logic [47:0]                       out_tdata,
  // out_tuser: is_pixel[0], out_of_range[1]
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,      // finished
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scd_pkg::LEN_W-1:0]         cfg_data
);
  import scd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = HW + WW + 1;

  typedef enum logic [1:0] {PH_IDLE, PH_LOW, PH_HIGH, PH_RUN} phase_t;

  typedef struct packed {
    logic              pix;
    logic              fin;
    logic              oor;
    logic [ADDR_W-1:0] addr;
    logic [RGB_W-1:0]  rgb;
  } res_t;

  // ---------------- configuration registers ----------------
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [LEN_W-1:0]    len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(320);
      height_r <= HEIGHT_W'(200);
      len_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        REG_LENGTH: len_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the build limits
  logic [CW-1:0] w_cmp, h_cmp;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  assign w_cmp = (CW'(width_r) < CW'(MAX_WIDTH)) ? CW'(width_r) : CW'(MAX_WIDTH);
  assign h_cmp = (CW'(height_r) < CW'(MAX_HEIGHT)) ? CW'(height_r) : CW'(MAX_HEIGHT);
  assign w_eff = WW'(w_cmp);
  assign h_eff = HW'(h_cmp);

  // ---------------- input fields ----------------
  logic [1:0]        cmd;
  logic [BYTE_W-1:0] s_byte;
  logic [PAL_AW-1:0] p_idx;
  logic [RGB_W-1:0]  p_rgb;
  logic              acc;

  assign cmd    = in_tuser;
  assign s_byte = in_tdata[7:0];
  assign p_idx  = in_tdata[15:8];
  assign p_rgb  = in_tdata[39:16];
  assign acc    = in_tvalid && in_tready;

  // ---------------- decode state ----------------
  phase_t            phase_r, phase_nxt;
  logic [CW-1:0]     column_r, column_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     run_r, run_nxt;
  logic [LEN_W-1:0]  bleft_r, bleft_nxt;
  logic [BYTE_W-1:0] low_r, low_nxt;

  logic          res_v, res_fin, res_pix, res_oor;
  logic          in_frame;
  logic [15:0]   word;
  logic [CW-1:0] val;
  logic [1:0]    op;
  logic [LEN_W-1:0] bl_two, bl_one;
  logic [CW-1:0] run_dec;
  pal_req_t      pal_req;

  assign in_frame = (row_r < h_cmp) && (column_r < w_cmp);
  assign word     = {s_byte, low_r};
  assign val      = word[15:2];
  assign op       = word[1:0];
  assign bl_two   = (bleft_r > LEN_W'(2)) ? bleft_r - LEN_W'(2) : '0;
  assign bl_one   = (bleft_r != '0) ? bleft_r - LEN_W'(1) : '0;
  assign run_dec  = run_r - CW'(1);

  always_comb begin
    phase_nxt  = phase_r;
    column_nxt = column_r;
    row_nxt    = row_r;
    run_nxt    = run_r;
    bleft_nxt  = bleft_r;
    low_nxt    = low_r;
    res_v      = 1'b0;
    res_fin    = 1'b0;
    res_pix    = 1'b0;
    res_oor    = 1'b0;
    if (acc) begin
      unique case (cmd)
        CMD_START: begin
          column_nxt = '0;
          row_nxt    = '0;
          run_nxt    = '0;
          low_nxt    = '0;
          bleft_nxt  = len_r;
          if (len_r == '0) begin
            phase_nxt = PH_IDLE;
            res_v     = 1'b1;
            res_fin   = 1'b1;
          end else begin
            phase_nxt = PH_LOW;
          end
        end
        CMD_BYTE: begin
          unique case (phase_r)
            PH_IDLE: ;
            PH_LOW: begin
              low_nxt   = s_byte;
              phase_nxt = PH_HIGH;
            end
            PH_HIGH: begin
              bleft_nxt = bl_two;
              if (op == OP_END) begin
                phase_nxt = PH_IDLE;
                res_v     = 1'b1;
                res_fin   = 1'b1;
              end else if (op == OP_RUN && val != '0) begin
                run_nxt   = val;
                phase_nxt = PH_RUN;
              end else begin
                if (op == OP_COL) column_nxt = val;
                else if (op == OP_ROW) row_nxt = val;
                else column_nxt = '0;    // empty run
                if (bl_two == '0) begin
                  phase_nxt = PH_IDLE;
                  res_v     = 1'b1;
                  res_fin   = 1'b1;
                end else begin
                  phase_nxt = PH_LOW;
                end
              end
            end
            PH_RUN: begin
              res_v      = 1'b1;
              res_pix    = in_frame;
              res_oor    = !in_frame;
              bleft_nxt  = bl_one;
              column_nxt = column_r + CW'(1);
              run_nxt    = run_dec;
              if (run_dec == '0) begin
                column_nxt = '0;
                // budget only checked once the run is done
                if (bl_one == '0) begin
                  phase_nxt = PH_IDLE;
                  res_fin   = 1'b1;
                end else begin
                  phase_nxt = PH_LOW;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;   // palette writes handled below, spare code ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      column_r <= '0;
      row_r    <= '0;
      run_r    <= '0;
      bleft_r  <= '0;
      low_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      column_r <= column_nxt;
      row_r    <= row_nxt;
      run_r    <= run_nxt;
      bleft_r  <= bleft_nxt;
      low_r    <= low_nxt;
    end
  end

  // ---------------- palette memory ----------------
  // Write and read both happen at the acceptance edge, so a write is seen
  // by any later request without forwarding.
  logic [RGB_W-1:0] pal_rd;

  always_comb begin
    pal_req.we    = acc && (cmd == CMD_PAL);
    pal_req.waddr = p_idx;
    pal_req.wdata = p_rgb;
    pal_req.re    = acc && (cmd == CMD_BYTE) && (phase_r == PH_RUN);
    pal_req.raddr = s_byte;
  end

  scd_palette u_palette (
    .clk     (clk),
    .req     (pal_req),
    .rd_data (pal_rd)
  );

  // ---------------- address stage ----------------
  logic          b_v_r;
  logic          b_pix_r, b_fin_r, b_oor_r;
  logic [HW-1:0] b_flip_r;
  logic [WW-1:0] b_col_r;
  logic [WW-1:0] b_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= acc && res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_pix_r  <= res_pix;
      b_fin_r  <= res_fin;
      b_oor_r  <= res_oor;
      b_flip_r <= HW'(h_cmp - CW'(1) - row_r);   // bottom-up row
      b_col_r  <= WW'(column_r);
      b_w_r    <= w_eff;
    end
  end

  logic [HW+WW-1:0] prod;
  logic [PW-1:0]    sum;
  res_t             push_d;

  assign prod = (HW+WW)'(b_flip_r) * (HW+WW)'(b_w_r);
  assign sum  = PW'(prod) + PW'(b_col_r);

  always_comb begin
    push_d.pix  = b_pix_r;
    push_d.fin  = b_fin_r;
    push_d.oor  = b_oor_r;
    push_d.addr = b_pix_r ? ADDR_W'(sum) : '0;
    push_d.rgb  = b_pix_r ? pal_rd : '0;
  end

  // ---------------- output queue ----------------
  res_t       e0_r, e0_nxt, e1_r, e1_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic [1:0] occ;
  logic       pop;

  assign pop = (q_cnt_r != 2'd0) && out_tready;
  assign occ = q_cnt_r + {1'b0, b_v_r};
  // room for the request in flight plus one more
  assign in_tready = (occ - {1'b0, pop}) < 2'd2;

  always_comb begin
    e0_nxt    = e0_r;
    e1_nxt    = e1_r;
    q_cnt_nxt = q_cnt_r - {1'b0, pop} + {1'b0, b_v_r};
    if (pop) begin
      if (q_cnt_r == 2'd2) begin
        e0_nxt = e1_r;
        if (b_v_r) e1_nxt = push_d;
      end else if (b_v_r) begin
        e0_nxt = push_d;
      end
    end else if (b_v_r) begin
      if (q_cnt_r == 2'd0) e0_nxt = push_d;
      else e1_nxt = push_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tlast  = e0_r.fin;
  assign out_tuser  = {e0_r.oor, e0_r.pix};
  assign out_tdata  = {7'd0, e0_r.rgb[7:0], e0_r.rgb[15:8], e0_r.rgb[23:16], e0_r.addr};

  // ---------------- assertions ----------------
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("output queue overflow");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd2 && !out_tready) |-> !in_tready)
    else $error("request accepted with full output queue");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (b_v_r && b_fin_r) |-> (phase_r == PH_IDLE))
    else $error("decode finished but decoder not idle");

  a_pix_oor: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_v) |=> !(b_pix_r && b_oor_r))
    else $error("pixel both written and dropped");

endmodule

### hw/rtl/scd_palette.sv
// ----------------------------------------------------------------------------
// scd_palette: color lookup memory
// 256 x 24 single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module scd_palette (
  input  logic                         clk,
  input  scd_pkg::pal_req_t            req,
  output logic [scd_pkg::RGB_W-1:0]    rd_data
);
  import scd_pkg::*;

  logic [RGB_W-1:0] mem [PAL_DEPTH];
  logic [RGB_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
